[src/cam_generation_trigger_core_assert.svh]
// Assertion macros for the CAM generation trigger block.
// Each use expects clk and arst_n in scope.
`ifndef CAM_GENERATION_TRIGGER_CORE_ASSERT_SVH
`define CAM_GENERATION_TRIGGER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CGT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define CGT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/cgt_pkg.sv]
// Shared types and constants for the CAM generation trigger block.
// No dependencies; the design modules and the testbench import this package.
`default_nettype none

package cgt_pkg;

	// Send reason codes as seen on the result channel
	typedef enum logic [1:0] {
		REASON_NONE    = 2'd0,
		REASON_FIXED   = 2'd1,
		REASON_DYN     = 2'd2,
		REASON_TIMEOUT = 2'd3
	} reason_t;

	// Configuration register indexes
	localparam logic [3:0] REG_MIN_INTERVAL = 4'd0;
	localparam logic [3:0] REG_MAX_INTERVAL = 4'd1;
	localparam logic [3:0] REG_HDG_THR      = 4'd2;
	localparam logic [3:0] REG_POS_THR      = 4'd3;
	localparam logic [3:0] REG_SPD_THR      = 4'd4;
	localparam logic [3:0] REG_DCC_EN       = 4'd5;
	localparam logic [3:0] REG_FIXED_RATE   = 4'd6;
	localparam logic [3:0] REG_LD_LIMIT     = 4'd7;

	// Register reset values
	localparam logic [15:0] MIN_INTERVAL_RST = 16'd100;
	localparam logic [15:0] MAX_INTERVAL_RST = 16'd1000;
	localparam logic [10:0] HDG_THR_RST      = 11'd40;
	localparam logic [31:0] POS_THR_SQ_RST   = 32'd160000;
	localparam logic [14:0] SPD_THR_RST      = 15'd50;
	localparam logic [7:0]  LD_LIMIT_RST     = 8'd3;

	// Heading circle in decidegrees, low frequency container period in ms
	localparam logic [11:0] HDG_FULL     = 12'd3600;
	localparam logic [11:0] HDG_HALF     = 12'd1800;
	localparam logic [31:0] LOW_FREQ_MS  = 32'd500;
	localparam logic [7:0]  CNT_MAX      = 8'hFF;

	// Live configuration; position threshold kept as its square
	typedef struct packed {
		logic [15:0] min_interval;
		logic [15:0] max_interval;
		logic [10:0] hdg_thr;
		logic [31:0] pos_thr_sq;
		logic [14:0] spd_thr;
		logic        dcc_en;
		logic        fixed_rate;
		logic [7:0]  ld_limit;
	} cfg_t;

	// One trigger tick
	typedef struct packed {
		logic [31:0]        now_ms;
		logic [11:0]        vehicle_heading;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [14:0] vehicle_speed;
		logic [15:0]        dcc_interval_ms;
	} item_t;

	// One decision
	typedef struct packed {
		logic        send_cam;
		logic        with_low_frequency;
		reason_t     send_reason;
		logic [15:0] current_interval_ms;
	} result_t;

endpackage

`default_nettype wire

[src/cgt_if.sv]
// Handshake channel interfaces: trigger ticks, decisions, register writes.
// Standalone; field widths follow the block's item and result formats.
`default_nettype none

interface cgt_item_if;
	logic               valid;
	logic               ready;
	logic [31:0]        now_ms;
	logic [11:0]        vehicle_heading;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [14:0] vehicle_speed;
	logic [15:0]        dcc_interval_ms;

	modport source (output valid, now_ms, vehicle_heading, pos_x, pos_y, vehicle_speed,
		dcc_interval_ms, input ready);
	modport sink (input valid, now_ms, vehicle_heading, pos_x, pos_y, vehicle_speed,
		dcc_interval_ms, output ready);
endinterface

interface cgt_result_if;
	logic        valid;
	logic        ready;
	logic        send_cam;
	logic        with_low_frequency;
	logic [1:0]  send_reason;
	logic [15:0] current_interval_ms;

	modport source (output valid, send_cam, with_low_frequency, send_reason,
		current_interval_ms, input ready);
	modport sink (input valid, send_cam, with_low_frequency, send_reason,
		current_interval_ms, output ready);
endinterface

interface cgt_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/cgt_cfg.sv]
// Configuration register file for the CAM generation trigger.
// Depends on cgt_pkg and cgt_cfg_if.
`default_nettype none

module cgt_cfg (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cgt_cfg_if.sink     wr,
	output cgt_pkg::cfg_t cfg
);
	import cgt_pkg::*;

	cfg_t cfg_q;
	logic wr_fire;

	// Writes are always taken
	assign wr.ready = 1'b1;
	assign wr_fire  = wr.valid;
	assign cfg      = cfg_q;

	// Update the addressed register; square the position threshold on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval <= MIN_INTERVAL_RST;
			cfg_q.max_interval <= MAX_INTERVAL_RST;
			cfg_q.hdg_thr      <= HDG_THR_RST;
			cfg_q.pos_thr_sq   <= POS_THR_SQ_RST;
			cfg_q.spd_thr      <= SPD_THR_RST;
			cfg_q.dcc_en       <= 1'b0;
			cfg_q.fixed_rate   <= 1'b0;
			cfg_q.ld_limit     <= LD_LIMIT_RST;
		end else if (wr_fire) begin
			case (wr.index)
				REG_MIN_INTERVAL: cfg_q.min_interval <= wr.data;
				REG_MAX_INTERVAL: cfg_q.max_interval <= wr.data;
				REG_HDG_THR:      cfg_q.hdg_thr      <= wr.data[10:0];
				REG_POS_THR:      cfg_q.pos_thr_sq   <= {16'd0, wr.data} * {16'd0, wr.data};
				REG_SPD_THR:      cfg_q.spd_thr      <= wr.data[14:0];
				REG_DCC_EN:       cfg_q.dcc_en       <= wr.data[0];
				REG_FIXED_RATE:   cfg_q.fixed_rate   <= wr.data[0];
				REG_LD_LIMIT:     cfg_q.ld_limit     <= wr.data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[src/cgt_core.sv]
// Send decision logic and the trigger history (last sent state, interval, counter).
// Depends on cgt_pkg and the assertion macro header.
`default_nettype none

module cgt_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire cgt_pkg::item_t item,
	input  wire cgt_pkg::cfg_t  cfg,
	output cgt_pkg::result_t    res
);
	import cgt_pkg::*;

	`include "cam_generation_trigger_core_assert.svh"

	logic [31:0]        last_send_q;
	logic [31:0]        last_low_q;
	logic               low_once_q;
	logic [15:0]        gen_q;
	logic [7:0]         cnt_q;
	logic [11:0]        last_hdg_q;
	logic signed [23:0] last_x_q;
	logic signed [23:0] last_y_q;
	logic signed [14:0] last_spd_q;

	logic [31:0]        elapsed;
	logic [15:0]        dcc_lo;
	logic [15:0]        earliest;
	logic               allowed;
	logic [11:0]        hdg_a;
	logic [11:0]        hdg_b;
	logic [11:0]        hdg_d;
	logic [11:0]        hdg_dist;
	logic               hdg_chg;
	logic signed [24:0] dx;
	logic signed [24:0] dy;
	logic [24:0]        ndx;
	logic [24:0]        ndy;
	logic [23:0]        ux;
	logic [23:0]        uy;
	logic [47:0]        sq_x;
	logic [47:0]        sq_y;
	logic [48:0]        dist_sq;
	logic               pos_chg;
	logic signed [15:0] ds;
	logic [15:0]        nds;
	logic [15:0]        us;
	logic               spd_chg;
	logic               dyn_chg;
	logic [7:0]         cnt_inc;
	logic [15:0]        elapsed_cap;
	logic [31:0]        low_elapsed;
	logic               low_due;
	reason_t            reason;
	logic               send;
	logic [15:0]        gen_next;
	logic [7:0]         cnt_next;
	logic               low_marked;

	// Elapsed time and earliest send time
	always_comb begin
		elapsed  = item.now_ms - last_send_q;
		dcc_lo   = (item.dcc_interval_ms > cfg.min_interval) ? item.dcc_interval_ms
			: cfg.min_interval;
		earliest = cfg.dcc_en ? ((dcc_lo < cfg.max_interval) ? dcc_lo : cfg.max_interval)
			: cfg.min_interval;
		allowed  = elapsed >= {16'd0, earliest};
	end

	// Heading change, shorter way round the circle
	always_comb begin
		hdg_a    = (item.vehicle_heading >= HDG_FULL) ? item.vehicle_heading - HDG_FULL
			: item.vehicle_heading;
		hdg_b    = (last_hdg_q >= HDG_FULL) ? last_hdg_q - HDG_FULL : last_hdg_q;
		hdg_d    = (hdg_a > hdg_b) ? hdg_a - hdg_b : hdg_b - hdg_a;
		hdg_dist = (hdg_d > HDG_HALF) ? HDG_FULL - hdg_d : hdg_d;
		hdg_chg  = hdg_dist > {1'b0, cfg.hdg_thr};
	end

	// Squared position distance against the squared threshold
	always_comb begin
		dx      = $signed({item.pos_x[23], item.pos_x}) - $signed({last_x_q[23], last_x_q});
		dy      = $signed({item.pos_y[23], item.pos_y}) - $signed({last_y_q[23], last_y_q});
		ndx     = -dx;
		ndy     = -dy;
		ux      = dx[24] ? ndx[23:0] : dx[23:0];
		uy      = dy[24] ? ndy[23:0] : dy[23:0];
		sq_x    = {24'd0, ux} * {24'd0, ux};
		sq_y    = {24'd0, uy} * {24'd0, uy};
		dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
		pos_chg = dist_sq > {17'd0, cfg.pos_thr_sq};
	end

	// Speed change
	always_comb begin
		ds      = $signed({item.vehicle_speed[14], item.vehicle_speed})
			- $signed({last_spd_q[14], last_spd_q});
		nds     = -ds;
		us      = ds[15] ? nds : ds;
		spd_chg = us > {1'b0, cfg.spd_thr};
		dyn_chg = hdg_chg || pos_chg || spd_chg;
	end

	// Pick the reason and the next interval and counter
	always_comb begin
		cnt_inc     = (cnt_q != CNT_MAX) ? cnt_q + 8'd1 : cnt_q;
		elapsed_cap = (elapsed < {16'd0, cfg.max_interval}) ? elapsed[15:0] : cfg.max_interval;
		reason      = REASON_NONE;
		gen_next    = gen_q;
		cnt_next    = cnt_q;
		if (allowed) begin
			if (cfg.fixed_rate) begin
				reason = REASON_FIXED;
			end else if (dyn_chg) begin
				reason   = REASON_DYN;
				gen_next = elapsed_cap;
				cnt_next = 8'd0;
			end else if (elapsed >= {16'd0, gen_q}) begin
				reason   = REASON_TIMEOUT;
				cnt_next = cnt_inc;
				if (cnt_inc >= cfg.ld_limit) begin
					gen_next = cfg.max_interval;
				end
			end
		end
		send        = reason != REASON_NONE;
		low_elapsed = item.now_ms - last_low_q;
		low_due     = send && (!low_once_q || low_elapsed >= LOW_FREQ_MS);

		res.send_cam            = send;
		res.with_low_frequency  = low_due;
		res.send_reason         = reason;
		res.current_interval_ms = gen_next;
	end

	// Commit history on each decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_send_q <= 32'd0;
			last_low_q  <= 32'd0;
			low_once_q  <= 1'b0;
			gen_q       <= MAX_INTERVAL_RST;
			cnt_q       <= 8'd0;
			last_hdg_q  <= 12'd0;
			last_x_q    <= 24'sd0;
			last_y_q    <= 24'sd0;
			last_spd_q  <= 15'sd0;
		end else if (fire) begin
			gen_q <= gen_next;
			cnt_q <= cnt_next;
			if (send) begin
				last_send_q <= item.now_ms;
				last_hdg_q  <= item.vehicle_heading;
				last_x_q    <= item.pos_x;
				last_y_q    <= item.pos_y;
				last_spd_q  <= item.vehicle_speed;
			end
			if (low_due) begin
				last_low_q <= item.now_ms;
				low_once_q <= 1'b1;
			end
		end
	end

	// Checks on history updates
	assign low_marked = low_once_q && (last_send_q == last_low_q);

	`CGT_ASSERT_NXT(a_hold_time_no_send, fire && !send, $stable(last_send_q), "send time moved")
	`CGT_ASSERT_NXT(a_dyn_clears_count, fire && reason == REASON_DYN, cnt_q == 8'd0, "count kept")
	`CGT_ASSERT_NXT(a_timeout_counts, fire && reason == REASON_TIMEOUT, cnt_q != 8'd0, "no count")
	`CGT_ASSERT_NXT(a_low_marks_once, fire && low_due, low_marked, "container time out of step")

endmodule

`default_nettype wire

[src/cam_generation_trigger_core.sv]
// CAM generation trigger: input register, decision logic, result register.
// A request is held in the input register, then moves on when the result is free.
// Throughput: one request per cycle unless a result waits; then one more is held.
// Reset (arst_n low): registers to reset values, history cleared, interval 1000 ms.
// Depends on cgt_pkg, cgt_if, cgt_cfg and cgt_core.
`default_nettype none

module cam_generation_trigger_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	cgt_item_if.sink      item,
	cgt_result_if.source  result,
	cgt_cfg_if.sink       cfg
);
	import cgt_pkg::*;

	cfg_t    cfg_live;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_q;
	logic    out_valid_q;
	logic    out_free;
	logic    fire;

	// Handshake: stage 1 moves when the result register is free or being drained
	assign out_free   = !out_valid_q || result.ready;
	assign fire       = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	cgt_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.cfg    (cfg_live)
	);

	cgt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_live),
		.res    (res_next)
	);

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.now_ms          <= item.now_ms;
			item_s1.vehicle_heading <= item.vehicle_heading;
			item_s1.pos_x           <= item.pos_x;
			item_s1.pos_y           <= item.pos_y;
			item_s1.vehicle_speed   <= item.vehicle_speed;
			item_s1.dcc_interval_ms <= item.dcc_interval_ms;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the decision until taken
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.send_cam            = res_q.send_cam;
	assign result.with_low_frequency  = res_q.with_low_frequency;
	assign result.send_reason         = res_q.send_reason;
	assign result.current_interval_ms = res_q.current_interval_ms;

endmodule

`default_nettype wire

[tb/tb_cam_generation_trigger_core.sv]
// Self-checking testbench for the CAM generation trigger core.
// Drives trigger ticks and register writes, predicts every decision and checks it.
// Depends on cgt_pkg, the cgt_if channel interfaces and the core itself.
`default_nettype none

module tb_cam_generation_trigger_core;
	import cgt_pkg::*;

	// Decision predictor with its own copy of the registers and send history
	class cam_decision_board;
		logic [15:0]        cfg_min;
		logic [15:0]        cfg_max;
		logic [10:0]        cfg_hdg;
		logic [15:0]        cfg_pos;
		logic [14:0]        cfg_spd;
		logic               cfg_dcc;
		logic               cfg_fixed;
		logic [7:0]         cfg_limit;
		logic [31:0]        sent_at;
		logic [31:0]        low_at;
		logic               low_done;
		logic [15:0]        gen_iv;
		logic [7:0]         calm_count;
		logic [11:0]        hdg_last;
		logic signed [23:0] x_last;
		logic signed [23:0] y_last;
		logic signed [14:0] spd_last;
		result_t            due_decisions[$];
		int                 fails;
		int                 seen;

		function new();
			cfg_min    = MIN_INTERVAL_RST;
			cfg_max    = MAX_INTERVAL_RST;
			cfg_hdg    = HDG_THR_RST;
			cfg_pos    = 16'd400;
			cfg_spd    = SPD_THR_RST;
			cfg_dcc    = 1'b0;
			cfg_fixed  = 1'b0;
			cfg_limit  = LD_LIMIT_RST;
			sent_at    = '0;
			low_at     = '0;
			low_done   = 1'b0;
			gen_iv     = MAX_INTERVAL_RST;
			calm_count = '0;
			hdg_last   = '0;
			x_last     = '0;
			y_last     = '0;
			spd_last   = '0;
			fails      = 0;
			seen       = 0;
		endfunction

		// Mirror one register write; unknown indexes are dropped
		function void write_reg(logic [3:0] idx, logic [15:0] data);
			case (idx)
				REG_MIN_INTERVAL: cfg_min = data;
				REG_MAX_INTERVAL: cfg_max = data;
				REG_HDG_THR:      cfg_hdg = data[10:0];
				REG_POS_THR:      cfg_pos = data;
				REG_SPD_THR:      cfg_spd = data[14:0];
				REG_DCC_EN:       cfg_dcc = data[0];
				REG_FIXED_RATE:   cfg_fixed = data[0];
				REG_LD_LIMIT:     cfg_limit = data[7:0];
				default: ;
			endcase
		endfunction

		// Work out the decision for one accepted tick and queue it
		function void note_tick(item_t t);
			logic [31:0]       elapsed;
			logic [31:0]       earliest;
			logic [31:0]       clamp;
			logic [11:0]       hn;
			logic [11:0]       hl;
			logic [11:0]       hd;
			longint            dx;
			longint            dy;
			longint            spd_d;
			longint unsigned   dist_sq;
			longint unsigned   thr_sq;
			bit                moved;
			reason_t           why;
			result_t           want;

			elapsed  = t.now_ms - sent_at;
			earliest = {16'd0, cfg_min};
			if (cfg_dcc) begin
				clamp    = (t.dcc_interval_ms > cfg_min) ? {16'd0, t.dcc_interval_ms}
					: {16'd0, cfg_min};
				earliest = (clamp < {16'd0, cfg_max}) ? clamp : {16'd0, cfg_max};
			end

			// heading change the short way round the circle
			hn = (t.vehicle_heading >= HDG_FULL) ? t.vehicle_heading - HDG_FULL
				: t.vehicle_heading;
			hl = (hdg_last >= HDG_FULL) ? hdg_last - HDG_FULL : hdg_last;
			hd = (hn > hl) ? hn - hl : hl - hn;
			if (hd > HDG_HALF)
				hd = HDG_FULL - hd;

			// squared distance against squared threshold
			dx      = longint'($signed(t.pos_x)) - longint'(x_last);
			dy      = longint'($signed(t.pos_y)) - longint'(y_last);
			dist_sq = longint'(dx * dx) + longint'(dy * dy);
			thr_sq  = longint'(cfg_pos) * longint'(cfg_pos);
			spd_d   = longint'($signed(t.vehicle_speed)) - longint'(spd_last);
			if (spd_d < 0)
				spd_d = -spd_d;
			moved = (hd > {1'b0, cfg_hdg}) || (dist_sq > thr_sq)
				|| (spd_d > longint'(cfg_spd));

			why = REASON_NONE;
			if (elapsed >= earliest) begin
				if (cfg_fixed) begin
					why = REASON_FIXED;
				end else if (moved) begin
					why        = REASON_DYN;
					gen_iv     = (elapsed < {16'd0, cfg_max}) ? elapsed[15:0] : cfg_max;
					calm_count = '0;
				end else if (elapsed >= {16'd0, gen_iv}) begin
					why = REASON_TIMEOUT;
					if (calm_count != CNT_MAX)
						calm_count = calm_count + 8'd1;
					if (calm_count >= cfg_limit)
						gen_iv = cfg_max;
				end
			end

			want.with_low_frequency = 1'b0;
			if (why != REASON_NONE) begin
				x_last   = t.pos_x;
				y_last   = t.pos_y;
				spd_last = t.vehicle_speed;
				hdg_last = t.vehicle_heading;
				sent_at  = t.now_ms;
				if (!low_done || (t.now_ms - low_at) >= LOW_FREQ_MS) begin
					want.with_low_frequency = 1'b1;
					low_at   = t.now_ms;
					low_done = 1'b1;
				end
			end
			want.send_cam            = (why != REASON_NONE);
			want.send_reason         = why;
			want.current_interval_ms = gen_iv;
			due_decisions.push_back(want);
		endfunction

		// Compare one decision with the oldest one due
		function void check_decision(result_t got);
			result_t want;
			bit      bad;

			seen++;
			if (due_decisions.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("decision with none due: send=%0b low=%0b reason=%0d interval=%0d",
						got.send_cam, got.with_low_frequency, got.send_reason,
						got.current_interval_ms);
				return;
			end
			want = due_decisions.pop_front();
			bad  = 1'b0;
			if (got.send_cam !== want.send_cam)
				bad = 1'b1;
			if (got.with_low_frequency !== want.with_low_frequency)
				bad = 1'b1;
			if (got.send_reason !== want.send_reason)
				bad = 1'b1;
			if (got.current_interval_ms !== want.current_interval_ms)
				bad = 1'b1;
			if (bad) begin
				fails++;
				if (fails <= 10) begin
					$display("mismatch %0d expected send=%0b low=%0b reason=%0d interval=%0d",
						seen, want.send_cam, want.with_low_frequency, want.send_reason,
						want.current_interval_ms);
					$display("mismatch %0d actual   send=%0b low=%0b reason=%0d interval=%0d",
						seen, got.send_cam, got.with_low_frequency, got.send_reason,
						got.current_interval_ms);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cgt_item_if   item_ch();
	cgt_result_if result_ch();
	cgt_cfg_if    cfg_ch();

	cam_decision_board board;

	// Vehicle track for well-formed tick sequences
	int unsigned veh_time;
	int          veh_hdg;
	int          veh_x;
	int          veh_y;
	int          veh_spd;
	int unsigned dt_hi;
	bit          steady;
	bit          pressure_req;

	cam_generation_trigger_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Clock, 12 units per period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hand one tick to the block, idling at random first unless steady
	task automatic send_tick(input item_t t);
		while (!steady && $urandom_range(0, 99) < 27) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid           <= 1'b1;
		item_ch.now_ms          <= t.now_ms;
		item_ch.vehicle_heading <= t.vehicle_heading;
		item_ch.pos_x           <= t.pos_x;
		item_ch.pos_y           <= t.pos_y;
		item_ch.vehicle_speed   <= t.vehicle_speed;
		item_ch.dcc_interval_ms <= t.dcc_interval_ms;
		do @(posedge clk); while (!item_ch.ready);
		board.note_tick(t);
	endtask

	// Write one register and mirror it
	task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		board.write_reg(idx, data);
	endtask

	// Load all registers for one phase, optionally poking an unused index
	task automatic apply_settings(input logic [15:0] mn, input logic [15:0] mx,
		input logic [15:0] hd, input logic [15:0] ps, input logic [15:0] sp,
		input logic [15:0] dc, input logic [15:0] fx, input logic [15:0] lm,
		input int unsigned step_hi, input bit stray);
		write_reg(REG_MIN_INTERVAL, mn);
		write_reg(REG_MAX_INTERVAL, mx);
		write_reg(REG_HDG_THR, hd);
		write_reg(REG_POS_THR, ps);
		write_reg(REG_SPD_THR, sp);
		write_reg(REG_DCC_EN, dc);
		write_reg(REG_FIXED_RATE, fx);
		write_reg(REG_LD_LIMIT, lm);
		if (stray)
			write_reg(REG_LD_LIMIT + 4'd1 + 4'($urandom_range(0, 7)), 16'($urandom));
		cfg_ch.valid <= 1'b0;
		dt_hi = step_hi;
	endtask

	// Stop offering and wait until every decision has come back
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (board.due_decisions.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic item_t mk_tick(input logic [31:0] now, input logic [11:0] h,
		input int x, input int y, input int s, input logic [15:0] d);
		item_t t;
		t.now_ms          = now;
		t.vehicle_heading = h;
		t.pos_x           = x[23:0];
		t.pos_y           = y[23:0];
		t.vehicle_speed   = s[14:0];
		t.dcc_interval_ms = d;
		return t;
	endfunction

	// Next tick: mostly a moving vehicle, some jumps, some pure noise
	function automatic item_t make_tick();
		item_t t;
		int    pick;

		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			t.now_ms          = $urandom;
			t.vehicle_heading = 12'($urandom);
			t.pos_x           = 24'($urandom);
			t.pos_y           = 24'($urandom);
			t.vehicle_speed   = 15'($urandom);
			t.dcc_interval_ms = 16'($urandom);
			veh_time = t.now_ms;
			veh_hdg  = int'(t.vehicle_heading);
			veh_x    = int'($signed(t.pos_x));
			veh_y    = int'($signed(t.pos_y));
			veh_spd  = int'($signed(t.vehicle_speed));
			return t;
		end
		veh_time += $urandom_range(0, dt_hi);
		if (pick < 28) begin
			case ($urandom_range(0, 3))
				0: veh_hdg = $urandom_range(0, 4095);
				1: veh_x = int'($urandom_range(0, 16777215)) - 8388608;
				2: veh_y = veh_y + int'($urandom_range(0, 4000)) - 2000;
				default: veh_spd = int'($urandom_range(0, 32767)) - 16384;
			endcase
		end else begin
			veh_hdg = (veh_hdg % 3600 + 3600 + int'($urandom_range(0, 60)) - 30) % 3600;
			veh_x   = veh_x + int'($urandom_range(0, 500)) - 250;
			veh_y   = veh_y + int'($urandom_range(0, 500)) - 250;
			veh_spd = veh_spd + int'($urandom_range(0, 80)) - 40;
		end
		t.now_ms          = veh_time;
		t.vehicle_heading = veh_hdg[11:0];
		t.pos_x           = veh_x[23:0];
		t.pos_y           = veh_y[23:0];
		t.vehicle_speed   = veh_spd[14:0];
		if ($urandom_range(0, 9) == 0)
			t.dcc_interval_ms = 16'($urandom);
		else
			t.dcc_interval_ms = 16'($urandom_range(0, 2 * dt_hi));
		veh_x   = int'($signed(t.pos_x));
		veh_y   = int'($signed(t.pos_y));
		veh_spd = int'($signed(t.vehicle_speed));
		return t;
	endfunction

	// Decision sink: check accepted decisions, stall at random unless steady, hold off on request
	initial begin : decision_sink
		int      hold_left;
		result_t got;

		hold_left = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.send_cam            = result_ch.send_cam;
				got.with_low_frequency  = result_ch.with_low_frequency;
				got.send_reason         = reason_t'(result_ch.send_reason);
				got.current_interval_ms = result_ch.current_interval_ms;
				board.check_decision(got);
			end
			if (pressure_req) begin
				pressure_req = 1'b0;
				hold_left    = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || ($urandom_range(0, 99) >= 27);
			end
		end
	end

	// Watchdog
	initial begin
		#(12 * 400000);
		$display("Verification failed");
		$finish;
	end

	// Main sequence: reset, directed ticks, then phases of random ticks
	initial begin
		board        = new();
		steady       = 1'b0;
		pressure_req = 1'b0;
		dt_hi        = 300;
		veh_time     = 0;
		veh_hdg      = 0;
		veh_x        = 0;
		veh_y        = 0;
		veh_spd      = 0;
		arst_n       = 1'b0;
		item_ch.valid           <= 1'b0;
		item_ch.now_ms          <= '0;
		item_ch.vehicle_heading <= '0;
		item_ch.pos_x           <= '0;
		item_ch.pos_y           <= '0;
		item_ch.vehicle_speed   <= '0;
		item_ch.dcc_interval_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks at reset settings: too early, thresholds, timeouts, extremes, wrap
		send_tick(mk_tick(32'd0, 12'd0, 0, 0, 0, 16'd0));
		send_tick(mk_tick(32'd99, 12'd0, 0, 0, 0, 16'd0));
		send_tick(mk_tick(32'd100, 12'd40, 400, 0, 50, 16'd0));
		send_tick(mk_tick(32'd150, 12'd41, 0, 0, 0, 16'd0));
		send_tick(mk_tick(32'd200, 12'd41, 401, 0, 0, 16'd0));
		send_tick(mk_tick(32'd260, 12'd41, 401, 0, 0, 16'd0));
		send_tick(mk_tick(32'd400, 12'd41, 401, 0, -51, 16'd0));
		send_tick(mk_tick(32'd600, 12'd3599, 401, 0, -51, 16'd0));
		send_tick(mk_tick(32'd800, 12'd3639, 401, 0, -51, 16'd0));
		send_tick(mk_tick(32'd1800, 12'd3639, 401, 0, -51, 16'd0));
		send_tick(mk_tick(32'd2800, 12'd3639, 401, 0, -51, 16'd0));
		send_tick(mk_tick(32'd3800, 12'd3639, 401, 0, -51, 16'd0));
		send_tick(mk_tick(32'd4800, 12'd3639, 401, 0, -51, 16'd0));
		send_tick(mk_tick(32'd5000, 12'd4095, 8388607, -8388608, 16383, 16'hFFFF));
		send_tick(mk_tick(32'd5200, 12'd3600, -8388608, 8388607, -16384, 16'd0));
		send_tick(mk_tick(32'd5400, 12'd1800, -8388608, 8388607, -16384, 16'd500));
		send_tick(mk_tick(32'd5700, 12'd1800, -8388608, 8388607, -16384, 16'd0));
		send_tick(mk_tick(32'hFFFF_FF00, 12'd1800, 0, 0, 0, 16'd0));
		send_tick(mk_tick(32'h0000_0010, 12'd1800, 0, 0, 0, 16'd0));
		send_tick(mk_tick(32'hFFFF_FFFF, 12'd2047, -1, -1, -1, 16'h8000));
		send_tick(mk_tick(32'h0000_0300, 12'd2047, -1, -1, -1, 16'h7FFF));
		send_tick(mk_tick(32'h0000_1000, 12'd0, 300, 300, 0, 16'd0));
		drain();

		for (int phase = 1; phase <= 7; phase++) begin
			steady = (phase == 4);
			case (phase)
				1: apply_settings(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
					400, 1'b0);
				2: apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFE, 16'd255, 300, 1'b1);
				3: apply_settings(16'd50, 16'd300, 16'd30, 16'd200, 16'd40, 16'd1, 16'd1,
					16'd2, 200, 1'b0);
				4: apply_settings(MIN_INTERVAL_RST, MAX_INTERVAL_RST, 16'd40, 16'd400, 16'd50,
					16'd1, 16'd0, 16'd3, 500, 1'b0);
				default: begin
					logic [15:0] mn;
					logic [15:0] mx;
					mn = 16'($urandom_range(0, 300));
					mx = 16'($urandom_range(0, 2000));
					apply_settings(mn, mx, 16'($urandom_range(0, 200)),
						16'($urandom_range(0, 2000)), 16'($urandom_range(0, 300)),
						16'($urandom_range(0, 1)), 16'($urandom_range(0, 3) == 0),
						16'($urandom_range(0, 8)), ((mx > mn) ? mx : mn) / 2 + 50, 1'b1);
				end
			endcase
			for (int n = 0; n < 210; n++) begin
				// hold the sink off mid-phase so the block backs up
				if (phase == 3 && n == 100)
					pressure_req = 1'b1;
				send_tick(make_tick());
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (board.fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
